FILE: rtl/tce_pkg.sv
// Package with the request and result types, codes and the serial sequence compare.
package tce_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] seg_seq;
        logic [31:0] seg_ack;
        logic        seg_syn;
        logic        seg_ack_flag;
        logic [15:0] payload_len;
        logic [7:0]  payload_tag;
        logic [31:0] initial_seq;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic        out_syn;
        logic        out_ack_flag;
        logic [15:0] out_len;
        logic [7:0]  out_tag;
        logic [1:0]  status;
        logic [3:0]  conn_state_out;
        logic        last;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE, S_DISPATCH, S_RPASS, S_FPURGE, S_FLUSH, S_TICK, S_FINAL
    } t_seq_state;

    localparam logic [1:0] OP_SEND  = 2'd0;
    localparam logic [1:0] OP_SEG   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CLOSE = 2'd3;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_DELIVER = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    localparam logic [1:0] STAT_ACCEPT   = 2'd0;
    localparam logic [1:0] STAT_REFUSED  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [1:0] STAT_IGNORED  = 2'd3;

    localparam logic [3:0] CS_LISTEN       = 4'd0;
    localparam logic [3:0] CS_SYN_SENT     = 4'd1;
    localparam logic [3:0] CS_SYN_RECEIVED = 4'd2;
    localparam logic [3:0] CS_ESTABLISHED  = 4'd3;
    localparam logic [3:0] CS_FIN_WAIT_1   = 4'd4;
    localparam logic [3:0] CS_CLOSE_WAIT   = 4'd9;
    localparam logic [3:0] CS_LAST_ACK     = 4'd10;

    localparam logic [31:0] SEQ_HALF = 32'hFFFF_FFFF >> 1;
    localparam logic [31:0] SEQ_LQ   = 32'hFFFF_FFFF >> 2;
    localparam logic [31:0] SEQ_UQ   = SEQ_HALF + SEQ_LQ;

    // quarter-window serial maximum
    function automatic logic [31:0] f_higher(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        if (a < SEQ_LQ && b > SEQ_UQ) begin
            r = a;
        end else if (a > SEQ_UQ && b < SEQ_LQ) begin
            r = b;
        end else begin
            r = (a > b) ? a : b;
        end
        return r;
    endfunction

endpackage

FILE: rtl/tcp_connection_engine_core.sv
// Simplified TCP endpoint: handshake, reorder buffer, in-flight list and send queue.
// Steps: start accepted in idle, dispatch, any scans, the status build, then the status result.
// The reorder pass sweeps the reorder buffer, repeated while in-order data is consumed; the
// in-flight purge and tick scan sweep the in-flight list; flush sweeps the send queue.
// One result per cycle at most, never stalled; busy drops as the status result is presented.
// Reset is synchronous: LISTEN, all buffers empty, timeout 200.
module tcp_connection_engine_core #(
    parameter int REORDER_DEPTH = 8,
    parameter int FLIGHT_DEPTH  = 16,
    parameter int QUEUE_DEPTH   = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tce_pkg::t_in   i_req,
    output logic           o_res_valid,
    output tce_pkg::t_out  o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [15:0]    i_cfg_data
);
    import tce_pkg::*;

    localparam int RCW  = $clog2(REORDER_DEPTH + 1);
    localparam int FCW  = $clog2(FLIGHT_DEPTH + 1);
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RIW  = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;
    localparam int FIW  = $clog2(FLIGHT_DEPTH);
    localparam int QIW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int IW0  = (RCW > FCW) ? RCW : FCW;
    localparam int IW   = (IW0 > QCW) ? IW0 : QCW;

    t_seq_state r_state, n_state;
    t_in        r_req;
    t_out       r_out, n_out;
    logic       r_out_v, n_out_v;
    logic [15:0] r_timeout;
    logic [3:0]  r_conn, n_conn;
    logic [31:0] r_lss, n_lss, r_lrs, n_lrs, r_lra, n_lra, r_tick, n_tick;
    logic [IW-1:0] r_idx, n_idx;
    logic r_pushed, n_pushed, r_flush, n_flush;
    logic r_ovf, n_ovf, r_ref, n_ref, r_ign, n_ign;
    logic [RCW-1:0] r_rcnt;
    logic [FCW-1:0] r_fcnt;
    logic [QCW-1:0] r_qcnt;

    logic [31:0] r_rseq [REORDER_DEPTH];
    logic [31:0] r_rack [REORDER_DEPTH];
    logic [15:0] r_rlen [REORDER_DEPTH];
    logic [7:0]  r_rtag [REORDER_DEPTH];
    logic [31:0] r_fseq [FLIGHT_DEPTH];
    logic [31:0] r_fack [FLIGHT_DEPTH];
    logic [25:0] r_finfo [FLIGHT_DEPTH];
    logic [31:0] r_ftime [FLIGHT_DEPTH];
    logic [23:0] r_q [QUEUE_DEPTH];

    logic        fl_app, fl_rm, fl_touch, ro_push, ro_rm, q_push, q_clr;
    logic [31:0] ap_seq, ap_ack;
    logic [25:0] ap_info;
    logic [RIW-1:0] ri;
    logic [FIW-1:0] fi;
    logic [QIW-1:0] qi;
    logic [31:0] e_seq, e_ack, f_seq, f_time;
    logic [25:0] f_info;
    logic [23:0] q_ent;

    assign ri     = r_idx[RIW-1:0];
    assign fi     = r_idx[FIW-1:0];
    assign qi     = r_idx[QIW-1:0];
    assign e_seq  = r_rseq[ri];
    assign e_ack  = r_rack[ri];
    assign f_seq  = r_fseq[fi];
    assign f_time = r_ftime[fi];
    assign f_info = r_finfo[fi];
    assign q_ent  = r_q[qi];

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_out    = '0;
        n_out_v  = 1'b0;
        n_conn   = r_conn;
        n_lss    = r_lss;
        n_lrs    = r_lrs;
        n_lra    = r_lra;
        n_tick   = r_tick;
        n_idx    = r_idx;
        n_pushed = r_pushed;
        n_flush  = r_flush;
        n_ovf    = r_ovf;
        n_ref    = r_ref;
        n_ign    = r_ign;
        fl_app   = 1'b0;
        fl_rm    = 1'b0;
        fl_touch = 1'b0;
        ro_push  = 1'b0;
        ro_rm    = 1'b0;
        q_push   = 1'b0;
        q_clr    = 1'b0;
        ap_seq   = '0;
        ap_ack   = '0;
        ap_info  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state  = S_DISPATCH;
                    n_ovf    = 1'b0;
                    n_ref    = 1'b0;
                    n_ign    = 1'b0;
                    n_flush  = 1'b0;
                    n_pushed = 1'b0;
                    n_idx    = '0;
                end
            end
            S_DISPATCH: begin
                n_state = S_FINAL;
                n_idx   = '0;
                case (r_req.opcode)
                    OP_SEND: begin
                        if (r_conn == CS_LISTEN) begin
                            n_lss   = r_req.initial_seq;
                            fl_app  = 1'b1;
                            ap_seq  = r_req.initial_seq;
                            ap_info = {1'b0, 1'b1, 8'd0, 16'd0};
                            n_conn  = CS_SYN_SENT;
                        end
                        if (r_conn > CS_ESTABLISHED) begin
                            n_ref = 1'b1;
                        end else begin
                            if (r_qcnt < QCW'(QUEUE_DEPTH)) begin
                                q_push = 1'b1;
                            end else begin
                                n_ovf = 1'b1;
                            end
                            if (r_conn == CS_ESTABLISHED) begin
                                n_state = S_FLUSH;
                            end
                        end
                    end
                    OP_SEG: begin
                        case (r_conn)
                            CS_LISTEN: begin
                                if (r_req.seg_syn) begin
                                    n_lrs   = r_req.seg_seq;
                                    n_lss   = r_req.initial_seq;
                                    fl_app  = 1'b1;
                                    ap_seq  = r_req.initial_seq;
                                    ap_ack  = r_req.seg_seq;
                                    ap_info = {1'b1, 1'b1, 8'd0, 16'd0};
                                    n_conn  = CS_SYN_RECEIVED;
                                end else begin
                                    n_ign = 1'b1;
                                end
                            end
                            CS_SYN_SENT: begin
                                if (r_req.seg_syn) begin
                                    n_lrs = r_req.seg_seq;
                                end
                                if (r_req.seg_syn && r_req.seg_ack_flag) begin
                                    if (r_lss == r_req.seg_ack) begin
                                        n_lra   = r_req.seg_ack;
                                        n_lss   = r_lss + 32'd1;
                                        fl_app  = 1'b1;
                                        ap_seq  = r_lss + 32'd1;
                                        ap_ack  = r_req.seg_seq;
                                        ap_info = {1'b1, 1'b0, 8'd0, 16'd0};
                                        n_conn  = CS_ESTABLISHED;
                                        ro_push = 1'b1;
                                        n_flush = 1'b1;
                                        n_state = S_RPASS;
                                    end else begin
                                        n_ign = 1'b1;
                                    end
                                end else if (r_req.seg_syn) begin
                                    n_lss   = r_lss + 32'd1;
                                    fl_app  = 1'b1;
                                    ap_seq  = r_lss + 32'd1;
                                    ap_ack  = r_req.seg_seq;
                                    ap_info = {1'b1, 1'b0, 8'd0, 16'd0};
                                    n_conn  = CS_SYN_RECEIVED;
                                end else begin
                                    n_ign = 1'b1;
                                end
                            end
                            CS_SYN_RECEIVED: begin
                                if (r_req.seg_ack_flag) begin
                                    n_lra   = r_req.seg_ack;
                                    n_conn  = CS_ESTABLISHED;
                                    ro_push = 1'b1;
                                    n_flush = 1'b1;
                                    n_state = S_RPASS;
                                end else begin
                                    n_ign = 1'b1;
                                end
                            end
                            CS_ESTABLISHED: begin
                                ro_push = 1'b1;
                                n_state = S_RPASS;
                            end
                            default: begin
                                n_ign = 1'b1;
                            end
                        endcase
                    end
                    OP_TICK: begin
                        n_tick  = r_tick + 32'd1;
                        n_state = S_TICK;
                    end
                    default: begin
                        case (r_conn)
                            CS_LISTEN, CS_SYN_SENT:           n_conn = CS_LISTEN;
                            CS_SYN_RECEIVED, CS_ESTABLISHED:  n_conn = CS_FIN_WAIT_1;
                            CS_CLOSE_WAIT:                    n_conn = CS_LAST_ACK;
                            default:                          n_conn = r_conn;
                        endcase
                    end
                endcase
                if (ro_push && r_rcnt >= RCW'(REORDER_DEPTH)) begin
                    ro_push = 1'b0;
                    n_ovf   = 1'b1;
                end
            end
            S_RPASS: begin
                if (r_idx < IW'(r_rcnt)) begin
                    n_lra = f_higher(r_lra, e_ack);
                    if (e_seq == r_lrs + 32'd1) begin
                        n_lrs    = r_lrs + 32'd1;
                        n_pushed = 1'b1;
                        ro_rm    = 1'b1;
                        if (r_rlen[ri] != 16'd0) begin
                            n_out_v        = 1'b1;
                            n_out.kind     = KIND_DELIVER;
                            n_out.out_seq  = e_seq;
                            n_out.out_len  = r_rlen[ri];
                            n_out.out_tag  = r_rtag[ri];
                        end
                    end else if (f_higher(e_seq, r_lrs) == r_lrs) begin
                        ro_rm = 1'b1;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_idx    = '0;
                    n_pushed = 1'b0;
                    if (!r_pushed) begin
                        n_state = S_FPURGE;
                    end
                end
            end
            S_FPURGE: begin
                if (r_idx < IW'(r_fcnt)) begin
                    if (f_higher(r_lra, f_seq) == r_lra) begin
                        fl_rm = 1'b1;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else begin
                    n_idx   = '0;
                    n_state = r_flush ? S_FLUSH : S_FINAL;
                end
            end
            S_FLUSH: begin
                if (r_idx < IW'(r_qcnt)) begin
                    n_lss   = r_lss + 32'd1;
                    fl_app  = 1'b1;
                    ap_seq  = r_lss + 32'd1;
                    ap_ack  = r_lra;
                    ap_info = {1'b1, 1'b0, q_ent};
                    n_idx   = r_idx + IW'(1);
                end else begin
                    q_clr   = 1'b1;
                    n_state = S_FINAL;
                end
            end
            S_TICK: begin
                if (r_idx < IW'(r_fcnt)) begin
                    if ((r_tick - f_time) > {16'd0, r_timeout}) begin
                        fl_touch           = 1'b1;
                        n_out_v            = 1'b1;
                        n_out.kind         = KIND_TX;
                        n_out.out_seq      = f_seq;
                        n_out.out_ack      = r_fack[fi];
                        n_out.out_syn      = f_info[24];
                        n_out.out_ack_flag = f_info[25];
                        n_out.out_len      = f_info[15:0];
                        n_out.out_tag      = f_info[23:16];
                    end
                    n_idx = r_idx + IW'(1);
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                n_out_v              = 1'b1;
                n_out.kind           = KIND_STATUS;
                n_out.conn_state_out = r_conn;
                n_out.last           = 1'b1;
                if (r_ref) begin
                    n_out.status = STAT_REFUSED;
                end else if (r_ovf) begin
                    n_out.status = STAT_OVERFLOW;
                end else if (r_ign) begin
                    n_out.status = STAT_IGNORED;
                end else begin
                    n_out.status = STAT_ACCEPT;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fl_app) begin
            n_out_v            = 1'b1;
            n_out.kind         = KIND_TX;
            n_out.out_seq      = ap_seq;
            n_out.out_ack      = ap_ack;
            n_out.out_syn      = ap_info[24];
            n_out.out_ack_flag = ap_info[25];
            n_out.out_len      = ap_info[15:0];
            n_out.out_tag      = ap_info[23:16];
            if (r_fcnt >= FCW'(FLIGHT_DEPTH)) begin
                fl_app = 1'b0;
                n_ovf  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v   <= 1'b0;
            r_timeout <= 16'd200;
            r_conn    <= CS_LISTEN;
            r_lss     <= '0;
            r_lrs     <= '0;
            r_lra     <= '0;
            r_tick    <= '0;
            r_idx     <= '0;
            r_pushed  <= 1'b0;
            r_flush   <= 1'b0;
            r_ovf     <= 1'b0;
            r_ref     <= 1'b0;
            r_ign     <= 1'b0;
            r_rcnt    <= '0;
            r_fcnt    <= '0;
            r_qcnt    <= '0;
        end else begin
            r_out_v  <= n_out_v;
            r_conn   <= n_conn;
            r_lss    <= n_lss;
            r_lrs    <= n_lrs;
            r_lra    <= n_lra;
            r_tick   <= n_tick;
            r_idx    <= n_idx;
            r_pushed <= n_pushed;
            r_flush  <= n_flush;
            r_ovf    <= n_ovf;
            r_ref    <= n_ref;
            r_ign    <= n_ign;
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            if (ro_push) begin
                r_rcnt <= r_rcnt + RCW'(1);
            end else if (ro_rm) begin
                r_rcnt <= r_rcnt - RCW'(1);
            end
            if (fl_app) begin
                r_fcnt <= r_fcnt + FCW'(1);
            end else if (fl_rm) begin
                r_fcnt <= r_fcnt - FCW'(1);
            end
            if (q_clr) begin
                r_qcnt <= '0;
            end else if (q_push) begin
                r_qcnt <= r_qcnt + QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (start && !busy) begin
            r_req <= i_req;
        end
        if (ro_push) begin
            r_rseq[r_rcnt[RIW-1:0]] <= r_req.seg_seq;
            r_rack[r_rcnt[RIW-1:0]] <= r_req.seg_ack;
            r_rlen[r_rcnt[RIW-1:0]] <= r_req.payload_len;
            r_rtag[r_rcnt[RIW-1:0]] <= r_req.payload_tag;
        end
        if (ro_rm) begin
            for (int j = 0; j < REORDER_DEPTH - 1; j++) begin
                if (RIW'(j) >= ri) begin
                    r_rseq[j] <= r_rseq[j + 1];
                    r_rack[j] <= r_rack[j + 1];
                    r_rlen[j] <= r_rlen[j + 1];
                    r_rtag[j] <= r_rtag[j + 1];
                end
            end
        end
        if (fl_app) begin
            r_fseq[r_fcnt[FIW-1:0]]  <= ap_seq;
            r_fack[r_fcnt[FIW-1:0]]  <= ap_ack;
            r_finfo[r_fcnt[FIW-1:0]] <= ap_info;
            r_ftime[r_fcnt[FIW-1:0]] <= r_tick;
        end
        if (fl_touch) begin
            r_ftime[fi] <= r_tick;
        end
        if (fl_rm) begin
            for (int j = 0; j < FLIGHT_DEPTH - 1; j++) begin
                if (FIW'(j) >= fi) begin
                    r_fseq[j]  <= r_fseq[j + 1];
                    r_fack[j]  <= r_fack[j + 1];
                    r_finfo[j] <= r_finfo[j + 1];
                    r_ftime[j] <= r_ftime[j + 1];
                end
            end
        end
        if (q_push) begin
            r_q[r_qcnt[QIW-1:0]] <= {r_req.payload_tag, r_req.payload_len};
        end
    end

    a_fcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= FCW'(FLIGHT_DEPTH) && r_rcnt <= RCW'(REORDER_DEPTH)
        && r_qcnt <= QCW'(QUEUE_DEPTH))
        else $error("buffer count out of range");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.last) |-> !busy)
        else $error("status issued while busy");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_no_dual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fl_app && fl_rm) && !(ro_push && ro_rm))
        else $error("append and remove in one cycle");

endmodule
